// ===== design/ctc_pkg.sv =====
// Package for the C subset token classifier: token kinds, the token record,
// the break-character decode and the keyword spelling tables.
// Used by ctc_scan and c_subset_token_classifier; depends on nothing else.
`default_nettype none

package ctc_pkg;

    localparam int unsigned MAX_TOKEN_LEN_DEF = 255;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned COL_W = 12;
    localparam int unsigned LEN_W = 8;
    localparam int unsigned KIND_W = 4;
    localparam int unsigned NUM_KW = 3;

    localparam logic [COL_W-1:0] COL_MAX = {COL_W{1'b1}};

    localparam logic [KIND_W-1:0] KIND_KEYWORD   = 4'd0;
    localparam logic [KIND_W-1:0] KIND_SEMI      = 4'd1;
    localparam logic [KIND_W-1:0] KIND_OPAR      = 4'd2;
    localparam logic [KIND_W-1:0] KIND_CPAR      = 4'd3;
    localparam logic [KIND_W-1:0] KIND_OBRACE    = 4'd4;
    localparam logic [KIND_W-1:0] KIND_CBRACE    = 4'd5;
    localparam logic [KIND_W-1:0] KIND_CONST     = 4'd6;
    localparam logic [KIND_W-1:0] KIND_IDENT     = 4'd7;
    localparam logic [KIND_W-1:0] KIND_NONE      = 4'd8;
    localparam logic [KIND_W-1:0] KIND_NOT_BREAK = 4'd15;

    localparam logic [1:0] KW_VOID   = 2'd0;
    localparam logic [1:0] KW_INT    = 2'd1;
    localparam logic [1:0] KW_RETURN = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [COL_W-1:0]  start;
        logic [LEN_W-1:0]  length;
        logic              last;
    } token_t;

    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } scan_t;

    function automatic logic [KIND_W-1:0] break_kind(input logic [CHAR_W-1:0] c);
        logic [KIND_W-1:0] k;
        case (c)
            ";":     k = KIND_SEMI;
            "(":     k = KIND_OPAR;
            ")":     k = KIND_CPAR;
            "{":     k = KIND_OBRACE;
            "}":     k = KIND_CBRACE;
            " ":     k = KIND_NONE;
            8'h0A:   k = KIND_NONE;
            8'h09:   k = KIND_NONE;
            default: k = KIND_NOT_BREAK;
        endcase
        return k;
    endfunction

    function automatic logic [LEN_W-1:0] kw_len(input logic [1:0] kw);
        logic [LEN_W-1:0] n;
        case (kw)
            KW_VOID:   n = 8'd4;
            KW_INT:    n = 8'd3;
            KW_RETURN: n = 8'd6;
            default:   n = 8'd0;
        endcase
        return n;
    endfunction

    function automatic logic [CHAR_W-1:0] kw_char(input logic [1:0] kw,
                                                  input logic [2:0] pos);
        logic [CHAR_W-1:0] ch;
        ch = 8'h00;
        case (kw)
            KW_VOID: begin
                case (pos)
                    3'd0:    ch = "v";
                    3'd1:    ch = "o";
                    3'd2:    ch = "i";
                    3'd3:    ch = "d";
                    default: ch = 8'h00;
                endcase
            end
            KW_INT: begin
                case (pos)
                    3'd0:    ch = "i";
                    3'd1:    ch = "n";
                    3'd2:    ch = "t";
                    default: ch = 8'h00;
                endcase
            end
            KW_RETURN: begin
                case (pos)
                    3'd0:    ch = "r";
                    3'd1:    ch = "e";
                    3'd2:    ch = "t";
                    3'd3:    ch = "u";
                    3'd4:    ch = "r";
                    3'd5:    ch = "n";
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== design/ctc_scan.sv =====
// Scanner for the C subset token classifier: line state and pending run,
// and the up to two tokens that one character yields.
// Depends on ctc_pkg.
`default_nettype none

module ctc_scan #(
    parameter int unsigned MAX_TOKEN_LEN = ctc_pkg::MAX_TOKEN_LEN_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [ctc_pkg::CHAR_W-1:0]    char_code,
    input  wire logic                          end_of_line,
    input  wire logic                          advance,
    output ctc_pkg::scan_t                     scan
);

    localparam int unsigned LEN_CAP_I = (MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255;
    localparam logic [ctc_pkg::LEN_W-1:0] LEN_CAP = ctc_pkg::LEN_W'(LEN_CAP_I);

    logic [ctc_pkg::COL_W-1:0]  column_reg, column_next;
    logic [ctc_pkg::COL_W-1:0]  start_reg, start_next;
    logic [ctc_pkg::LEN_W-1:0]  length_reg, length_next;
    logic                       digits_reg, digits_next;
    logic [ctc_pkg::NUM_KW-1:0] cand_reg, cand_next;

    logic [ctc_pkg::KIND_W-1:0] bk;
    logic                       is_break;
    logic [ctc_pkg::COL_W-1:0]  start_upd;
    logic [ctc_pkg::LEN_W-1:0]  length_upd;
    logic                       digits_upd;
    logic [ctc_pkg::NUM_KW-1:0] cand_upd;
    logic [ctc_pkg::NUM_KW-1:0] kw_hit;
    logic                       emit_run;
    logic [ctc_pkg::KIND_W-1:0] run_kind;
    ctc_pkg::token_t            run_tok;
    ctc_pkg::token_t            brk_tok;

    always_comb
    begin
        bk         = ctc_pkg::break_kind(char_code);
        is_break   = (bk != ctc_pkg::KIND_NOT_BREAK);
        start_upd  = start_reg;
        length_upd = length_reg;
        digits_upd = digits_reg;
        cand_upd   = cand_reg;
        if (!is_break)
        begin
            if (length_reg == '0)
            begin
                start_upd = column_reg;
            end
            for (int k = 0; k < ctc_pkg::NUM_KW; k++)
            begin
                if (length_reg >= ctc_pkg::kw_len(2'(k)) ||
                    ctc_pkg::kw_char(2'(k), length_reg[2:0]) != char_code)
                begin
                    cand_upd[k] = 1'b0;
                end
            end
            if (char_code < "0" || char_code > "9")
            begin
                digits_upd = 1'b0;
            end
            if (length_reg < LEN_CAP)
            begin
                length_upd = length_reg + 1'b1;
            end
        end

        for (int k = 0; k < ctc_pkg::NUM_KW; k++)
        begin
            kw_hit[k] = cand_upd[k] && (length_upd == ctc_pkg::kw_len(2'(k)));
        end
        if (|kw_hit)
        begin
            run_kind = ctc_pkg::KIND_KEYWORD;
        end
        else if (digits_upd)
        begin
            run_kind = ctc_pkg::KIND_CONST;
        end
        else
        begin
            run_kind = ctc_pkg::KIND_IDENT;
        end

        emit_run = (is_break || end_of_line) && (length_upd != '0);

        run_tok.kind   = run_kind;
        run_tok.start  = start_upd;
        run_tok.length = length_upd;
        run_tok.last   = !is_break;

        brk_tok.kind   = bk;
        brk_tok.start  = column_reg;
        brk_tok.length = ctc_pkg::LEN_W'(1);
        brk_tok.last   = 1'b1;

        scan.count = {1'b0, emit_run} + {1'b0, is_break};
        scan.tok0  = emit_run ? run_tok : brk_tok;
        scan.tok1  = brk_tok;

        column_next = column_reg;
        start_next  = start_reg;
        length_next = length_reg;
        digits_next = digits_reg;
        cand_next   = cand_reg;
        if (advance)
        begin
            if (end_of_line)
            begin
                column_next = '0;
            end
            else if (column_reg != ctc_pkg::COL_MAX)
            begin
                column_next = column_reg + 1'b1;
            end
            if (end_of_line || emit_run)
            begin
                start_next  = '0;
                length_next = '0;
                digits_next = 1'b1;
                cand_next   = '1;
            end
            else
            begin
                start_next  = start_upd;
                length_next = length_upd;
                digits_next = digits_upd;
                cand_next   = cand_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            start_reg  <= '0;
            length_reg <= '0;
            digits_reg <= 1'b1;
            cand_reg   <= '1;
        end
        else
        begin
            column_reg <= column_next;
            start_reg  <= start_next;
            length_reg <= length_next;
            digits_reg <= digits_next;
            cand_reg   <= cand_next;
        end
    end

    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= LEN_CAP)
        else $error("pending length beyond cap");

    a_empty_run_clean: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg == '0 |-> (digits_reg && cand_reg == '1 && start_reg == '0))
        else $error("empty run with stale flags");

    a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && end_of_line |=> (column_reg == '0 && length_reg == '0))
        else $error("line end did not clear state");

endmodule

`default_nettype wire

// ===== design/c_subset_token_classifier.sv =====
// Top level of the C subset token classifier: input register, scanner and
// two-entry result buffer on stream ports.
// Depends on ctc_pkg and ctc_scan.
`default_nettype none

// Takes one character per cycle on the slave stream while s_tready is high (tlast
// marks the last character of a line) and emits one item per token on the
// master stream. A character that yields no token never stalls; a break
// character that also closes a pending run yields two tokens and holds back
// the next character, since the result buffer hands out one token per cycle
// while m_tready is high. An accepted character is held in the input
// register, its tokens in the result buffer. Each token carries its kind in
// tuser, start column and length in tdata, and tlast on the final token of its character.
module c_subset_token_classifier #(
    parameter int unsigned MAX_TOKEN_LEN = ctc_pkg::MAX_TOKEN_LEN_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,   // end_of_line
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [11:0] token_start, [19:12] token_length, rest 0
    output logic [3:0]       m_tuser,   // [3:0] token_kind
    output logic             m_tlast    // last_of_run
);

    logic                          in_valid_reg, in_valid_next;
    logic [ctc_pkg::CHAR_W-1:0]    char_reg;
    logic                          eol_reg;
    logic [1:0]                    cnt_reg, cnt_next;
    ctc_pkg::token_t               out0_reg, out0_next;
    ctc_pkg::token_t               out1_reg, out1_next;
    ctc_pkg::scan_t                scan;
    logic                          advance;
    logic                          pair_free;
    logic                          out_fire;

    ctc_scan #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_code   (char_reg),
        .end_of_line (eol_reg),
        .advance     (advance),
        .scan        (scan)
    );

    always_comb
    begin
        out_fire  = m_tvalid && m_tready;
        pair_free = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);
        advance   = in_valid_reg && (scan.count == 2'd0 || pair_free);
        s_tready  = !in_valid_reg || advance;

        in_valid_next = in_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end

        cnt_next  = cnt_reg;
        out0_next = out0_reg;
        out1_next = out1_reg;
        if (advance && scan.count != 2'd0)
        begin
            cnt_next  = scan.count;
            out0_next = scan.tok0;
            out1_next = scan.tok1;
        end
        else if (out_fire)
        begin
            if (cnt_reg == 2'd2)
            begin
                cnt_next  = 2'd1;
                out0_next = out1_reg;
            end
            else
            begin
                cnt_next = 2'd0;
            end
        end

        m_tvalid = (cnt_reg != 2'd0);
        m_tdata  = {4'b0000, out0_reg.length, out0_reg.start};
        m_tuser  = out0_reg.kind;
        m_tlast  = out0_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            cnt_reg      <= 2'd0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready)
        begin
            char_reg <= s_tdata;
            eol_reg  <= s_tlast;
        end
        out0_reg <= out0_next;
        out1_reg <= out1_next;
    end

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> (!out0_reg.last && out1_reg.last))
        else $error("token pair out of order");

    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && cnt_reg == 2'd2 |=> (m_tvalid && m_tlast))
        else $error("second token lost");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        advance && scan.count != 2'd0 |-> (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && out_fire)))
        else $error("result buffer overwritten");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg)
        else $error("input stalled while empty");

endmodule

`default_nettype wire
